### rtl/vnsl_pkg.sv
// Package for the nearest-seed labeling block.
// Holds the command and result word types, the tree node type and shared helpers.
// Used by every file under rtl.
package vnsl_pkg;

	localparam int MAX_SEEDS = 64;
	localparam int IDX_W     = 6;
	localparam int COORD_W   = 8;
	localparam int LABEL_W   = 8;
	localparam int CNT_W     = 7;
	localparam int DIST_W    = 2 * COORD_W + 1;

	typedef enum logic {
		ACT_LOAD  = 1'b0,
		ACT_QUERY = 1'b1
	} action_t;

	typedef struct packed {
		logic                 action;
		logic [IDX_W-1:0]     seed_index;
		logic [COORD_W-1:0]   coord_x;
		logic [COORD_W-1:0]   coord_y;
		logic [LABEL_W-1:0]   seed_label;
	} in_word_t;

	typedef struct packed {
		logic [LABEL_W-1:0]   pixel_label;
		logic [IDX_W-1:0]     nearest_index;
	} out_word_t;

	typedef struct packed {
		logic                 vld;
		logic [DIST_W-1:0]    dsq;
		logic [IDX_W-1:0]     idx;
		logic [LABEL_W-1:0]   label;
	} node_t;

	function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
			input logic [COORD_W-1:0] b);
		abs_diff = (a > b) ? (a - b) : (b - a);
	endfunction

	// lower index wins a tie
	function automatic node_t pick(input node_t l, input node_t r);
		pick = (r.vld && (!l.vld || (r.dsq < l.dsq))) ? r : l;
	endfunction

endpackage

### rtl/voronoi_nearest_seed_label_unit.sv
// Top level of the nearest-seed labeling block: seed table, distance lanes, min tree.
// Depends on vnsl_pkg and vnsl_min_tree.
//
// Usage:
//   Command channel: drive cmd and pulse start; a word is taken at every edge with
//   start high and busy low. busy is never raised, so one word enters each cycle.
//   action load writes the seed entry at once and gives no result; a query that
//   follows in the next cycle already sees it.
//   Result channel: result_valid is high for one cycle with result holding the
//   label and index of the nearest active seed. The receiver cannot stall.
//   Pipeline: a query passes one register for the per-seed differences, one for
//   the squares and one per tree level before its result comes out.
//   Throughput: one word per cycle, set by the fully pipelined lane array.
//   Configuration: cfg_we with cfg_data writes the active seed count; write only
//   while no query is in flight.
//   Reset: clears the pipeline valid bits and sets the active count to 64; the
//   seed table is not cleared and must be loaded before it is queried.
module voronoi_nearest_seed_label_unit #(
	parameter int NUM_SEEDS = vnsl_pkg::MAX_SEEDS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  vnsl_pkg::in_word_t           cmd,
	input  logic                         cfg_we,
	input  logic [vnsl_pkg::CNT_W-1:0]   cfg_data,
	output logic                         result_valid,
	output vnsl_pkg::out_word_t          result
);

	localparam int LEVELS = (NUM_SEEDS <= 2) ? 1 : $clog2(NUM_SEEDS);
	localparam int LANES  = 1 << LEVELS;
	localparam int LAT    = LEVELS + 2;
	localparam int CMP_W  = vnsl_pkg::IDX_W + 2;

	logic [vnsl_pkg::COORD_W-1:0] seed_x_q   [NUM_SEEDS];
	logic [vnsl_pkg::COORD_W-1:0] seed_y_q   [NUM_SEEDS];
	logic [vnsl_pkg::LABEL_W-1:0] seed_lab_q [NUM_SEEDS];
	logic [vnsl_pkg::CNT_W-1:0]   active_q;

	logic [CMP_W-1:0] cnt_eff;
	logic             load_en;
	logic             query_en;

	logic                          vld_s1;
	logic [vnsl_pkg::COORD_W-1:0]  dx_s1  [LANES];
	logic [vnsl_pkg::COORD_W-1:0]  dy_s1  [LANES];
	logic [vnsl_pkg::LABEL_W-1:0]  lab_s1 [LANES];
	logic [LANES-1:0]              lv_s1;

	logic              vld_s2;
	vnsl_pkg::node_t   node_s2 [LANES];

	logic              tree_vld;
	vnsl_pkg::node_t   tree_node;

	assign busy     = 1'b0;
	assign load_en  = start && !busy && (cmd.action == vnsl_pkg::ACT_LOAD);
	assign query_en = start && !busy && (cmd.action == vnsl_pkg::ACT_QUERY);

	always_comb begin
		if (active_q == '0) begin
			cnt_eff = CMP_W'(1);
		end else if (CMP_W'(active_q) > CMP_W'(NUM_SEEDS)) begin
			cnt_eff = CMP_W'(NUM_SEEDS);
		end else begin
			cnt_eff = CMP_W'(active_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= vnsl_pkg::CNT_W'(vnsl_pkg::MAX_SEEDS);
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
		end else begin
			if (cfg_we) begin
				active_q <= cfg_data;
			end
			vld_s1 <= query_en;
			vld_s2 <= vld_s1;
		end
	end

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		if (i < NUM_SEEDS) begin : g_seed
			always_ff @(posedge clk) begin
				if (load_en && (32'(cmd.seed_index) == i)) begin
					seed_x_q[i]   <= cmd.coord_x;
					seed_y_q[i]   <= cmd.coord_y;
					seed_lab_q[i] <= cmd.seed_label;
				end
				dx_s1[i]  <= vnsl_pkg::abs_diff(seed_x_q[i], cmd.coord_x);
				dy_s1[i]  <= vnsl_pkg::abs_diff(seed_y_q[i], cmd.coord_y);
				lab_s1[i] <= seed_lab_q[i];
				lv_s1[i]  <= CMP_W'(i) < cnt_eff;
			end
		end else begin : g_pad
			always_ff @(posedge clk) begin
				dx_s1[i]  <= '0;
				dy_s1[i]  <= '0;
				lab_s1[i] <= '0;
				lv_s1[i]  <= 1'b0;
			end
		end

		always_ff @(posedge clk) begin
			node_s2[i].vld   <= lv_s1[i];
			node_s2[i].dsq   <= vnsl_pkg::DIST_W'(dx_s1[i] * dx_s1[i])
				+ vnsl_pkg::DIST_W'(dy_s1[i] * dy_s1[i]);
			node_s2[i].idx   <= vnsl_pkg::IDX_W'(i);
			node_s2[i].label <= lab_s1[i];
		end
	end

	vnsl_min_tree #(
		.LANES  (LANES),
		.LEVELS (LEVELS)
	) u_tree (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s2),
		.in_nodes (node_s2),
		.out_vld  (tree_vld),
		.out_node (tree_node)
	);

	assign result_valid         = tree_vld;
	assign result.pixel_label   = tree_node.label;
	assign result.nearest_index = tree_node.idx;

	a_result_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(query_en, LAT))
		else $error("result without a matching query");

	a_query_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> ##LEVELS result_valid)
		else $error("query lost in tree");

	a_index_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (32'(result.nearest_index) < NUM_SEEDS))
		else $error("winning index beyond table");

	a_winner_active: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> tree_node.vld)
		else $error("winning lane not active");

endmodule

### rtl/vnsl_min_tree.sv
// Registered minimum tree over the seed lanes, one register per level.
// Depends on vnsl_pkg for node_t and pick.
module vnsl_min_tree #(
	parameter int LANES  = 64,
	parameter int LEVELS = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  vnsl_pkg::node_t   in_nodes [LANES],
	output logic              out_vld,
	output vnsl_pkg::node_t   out_node
);

	vnsl_pkg::node_t lvl_s [1:LEVELS][LANES];
	logic [LEVELS:1] vld_s;

	for (genvar k = 1; k <= LEVELS; k++) begin : g_lvl
		if (k == 1) begin : g_vin
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else begin
					vld_s[k] <= in_vld;
				end
			end
		end else begin : g_vchain
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end

		for (genvar j = 0; j < LANES; j++) begin : g_node
			if (j < (LANES >> k)) begin : g_live
				if (k == 1) begin : g_first
					always_ff @(posedge clk) begin
						lvl_s[k][j] <= vnsl_pkg::pick(in_nodes[2*j], in_nodes[2*j+1]);
					end
				end else begin : g_rest
					always_ff @(posedge clk) begin
						lvl_s[k][j] <= vnsl_pkg::pick(lvl_s[k-1][2*j], lvl_s[k-1][2*j+1]);
					end
				end
			end else begin : g_pad
				always_ff @(posedge clk) begin
					lvl_s[k][j] <= '0;
				end
			end
		end
	end

	assign out_vld  = vld_s[LEVELS];
	assign out_node = lvl_s[LEVELS][0];

endmodule

### sim/vnsl_checker.sv
// Checker for the nearest-seed labeling block: keeps its own seed table and count,
// predicts the label and index of each query, and compares every result word.
// Depends on vnsl_pkg; instantiated beside the block by tb_voronoi_nearest_seed_label_unit.
`timescale 1ns / 1ps
module vnsl_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         busy,
	input  vnsl_pkg::in_word_t           cmd,
	input  logic                         cfg_we,
	input  logic [vnsl_pkg::CNT_W-1:0]   cfg_data,
	input  logic                         result_valid,
	input  vnsl_pkg::out_word_t          result,
	output int                           fail_count,
	output int                           pending,
	output int                           query_count
);

	localparam int FIFO_DEPTH = 16;

	logic [vnsl_pkg::COORD_W-1:0] seed_x [vnsl_pkg::MAX_SEEDS];
	logic [vnsl_pkg::COORD_W-1:0] seed_y [vnsl_pkg::MAX_SEEDS];
	logic [vnsl_pkg::LABEL_W-1:0] seed_lab [vnsl_pkg::MAX_SEEDS];
	logic [vnsl_pkg::CNT_W-1:0]   live_count;
	vnsl_pkg::out_word_t          want_fifo [FIFO_DEPTH];
	int                           wr_ptr;
	int                           rd_ptr;

	function automatic int sq_dist(input logic [vnsl_pkg::COORD_W-1:0] ax, ay, bx, by);
		int dx, dy;
		dx = (ax > bx) ? ax - bx : bx - ax;
		dy = (ay > by) ? ay - by : by - ay;
		return dx * dx + dy * dy;
	endfunction

	function automatic vnsl_pkg::out_word_t nearest_seed(
			input logic [vnsl_pkg::COORD_W-1:0] px, py);
		int n, win, best, d;
		vnsl_pkg::out_word_t w;
		n = live_count;
		if (n < 1) n = 1;
		if (n > vnsl_pkg::MAX_SEEDS) n = vnsl_pkg::MAX_SEEDS;
		win = 0;
		best = sq_dist(seed_x[0], seed_y[0], px, py);
		for (int i = 1; i < n; i++) begin
			d = sq_dist(seed_x[i], seed_y[i], px, py);
			if (d < best) begin
				best = d;
				win = i;
			end
		end
		w.pixel_label = seed_lab[win];
		w.nearest_index = win[vnsl_pkg::IDX_W-1:0];
		return w;
	endfunction

	assign pending = wr_ptr - rd_ptr;

	always @(posedge clk or negedge arst_n) begin
		vnsl_pkg::out_word_t want;
		if (!arst_n) begin
			live_count <= vnsl_pkg::CNT_W'(64);
			fail_count <= 0;
			query_count <= 0;
			wr_ptr <= 0;
			rd_ptr <= 0;
		end else begin
			if (result_valid) begin
				if (wr_ptr == rd_ptr) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("unexpected result word label=%0d index=%0d",
							result.pixel_label, result.nearest_index);
				end else begin
					want = want_fifo[rd_ptr % FIFO_DEPTH];
					rd_ptr <= rd_ptr + 1;
					if (want !== result) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("mismatch: expected label=%0d index=%0d, %s%0d index=%0d",
								want.pixel_label, want.nearest_index, "got label=",
								result.pixel_label, result.nearest_index);
					end
				end
			end
			if (cfg_we)
				live_count <= cfg_data;
			if (start && !busy) begin
				if (cmd.action == vnsl_pkg::ACT_LOAD) begin
					seed_x[cmd.seed_index] <= cmd.coord_x;
					seed_y[cmd.seed_index] <= cmd.coord_y;
					seed_lab[cmd.seed_index] <= cmd.seed_label;
				end else begin
					want_fifo[wr_ptr % FIFO_DEPTH] <= nearest_seed(cmd.coord_x, cmd.coord_y);
					wr_ptr <= wr_ptr + 1;
					query_count <= query_count + 1;
				end
			end
		end
	end
endmodule

### sim/tb_voronoi_nearest_seed_label_unit.sv
// Testbench top for voronoi_nearest_seed_label_unit: drives load and query words
// and active-count writes, with random sender gaps; vnsl_checker does the checking.
// Depends on vnsl_pkg, the block and vnsl_checker.
`timescale 1ns / 1ps
module tb_voronoi_nearest_seed_label_unit;

	localparam int CYCLE_LIMIT = 200000;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          start = 1'b0;
	logic                          busy;
	vnsl_pkg::in_word_t            cmd = '0;
	logic                          cfg_we = 1'b0;
	logic [vnsl_pkg::CNT_W-1:0]    cfg_data = '0;
	logic                          result_valid;
	vnsl_pkg::out_word_t           result;
	int                            fail_count, pending, query_count;
	int                            cycles = 0;
	int                            gap_pct = 0;
	int                            words_sent = 0;

	always #2 clk = ~clk;

	voronoi_nearest_seed_label_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.cfg_we(cfg_we), .cfg_data(cfg_data), .result_valid(result_valid), .result(result)
	);

	vnsl_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.cfg_we(cfg_we), .cfg_data(cfg_data), .result_valid(result_valid), .result(result),
		.fail_count(fail_count), .pending(pending), .query_count(query_count)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL voronoi_nearest_seed_label_unit");
			$finish;
		end
	end

	task automatic send_word(input vnsl_pkg::in_word_t w);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd <= w;
		@(posedge clk);
		while (busy) @(posedge clk);
		words_sent++;
	endtask

	task automatic load_seed(input int idx, input int x, input int y, input int lab);
		vnsl_pkg::in_word_t w;
		w.action = vnsl_pkg::ACT_LOAD;
		w.seed_index = idx[vnsl_pkg::IDX_W-1:0];
		w.coord_x = x[vnsl_pkg::COORD_W-1:0];
		w.coord_y = y[vnsl_pkg::COORD_W-1:0];
		w.seed_label = lab[vnsl_pkg::LABEL_W-1:0];
		send_word(w);
	endtask

	task automatic query_pixel(input int x, input int y);
		vnsl_pkg::in_word_t w;
		w.action = vnsl_pkg::ACT_QUERY;
		w.seed_index = vnsl_pkg::IDX_W'($urandom);
		w.coord_x = x[vnsl_pkg::COORD_W-1:0];
		w.coord_y = y[vnsl_pkg::COORD_W-1:0];
		w.seed_label = vnsl_pkg::LABEL_W'($urandom);
		send_word(w);
	endtask

	task automatic drain_and_write(input int count);
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= count[vnsl_pkg::CNT_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_phase(input int n, input int span);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 25)
				load_seed($urandom_range(63), $urandom_range(255), $urandom_range(255),
					$urandom_range(255));
			else if (r < 45 && span < 256)
				query_pixel($urandom_range(span), $urandom_range(span));
			else
				query_pixel($urandom_range(255), $urandom_range(255));
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// fill the whole table before any query
		for (int i = 0; i < 64; i++)
			load_seed(i, $urandom_range(255), $urandom_range(255), $urandom_range(255));
		// directed: corners, ties on equal seeds, extreme fields
		load_seed(0, 0, 0, 8'h00);
		load_seed(1, 255, 255, 8'hFF);
		load_seed(2, 0, 0, 8'hAA);
		load_seed(63, 128, 128, 8'h55);
		query_pixel(0, 0);
		query_pixel(255, 255);
		query_pixel(255, 0);
		query_pixel(0, 255);
		query_pixel(128, 128);
		drain_and_write(1);
		query_pixel(255, 255);
		query_pixel(7, 9);
		drain_and_write(0);
		query_pixel(200, 3);
		drain_and_write(127);
		query_pixel(128, 127);
		load_seed(5, 17, 17, 8'h3C);
		query_pixel(17, 17);
		drain_and_write(64);
		query_pixel(17, 17);

		gap_pct = 20;
		random_phase(150, 255);
		drain_and_write($urandom_range(2, 10));
		random_phase(100, 255);
		gap_pct = 70;
		drain_and_write(63);
		random_phase(150, 31);
		drain_and_write(2);
		random_phase(100, 255);
		gap_pct = 0;
		drain_and_write(64);
		random_phase(150, 255);
		drain_and_write($urandom_range(1, 64));
		random_phase(150, 63);

		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		$display("Sent %0d words, %0d of them pixel queries, over active counts 0 to 127.",
			words_sent, query_count);
		if (fail_count == 0)
			$display("PASS voronoi_nearest_seed_label_unit");
		else
			$display("FAIL voronoi_nearest_seed_label_unit");
		$finish;
	end
endmodule
